// ----- rtl/vlpd_pkg.sv -----
`default_nettype none

package vlpd_pkg;

    // Parser phases, one-hot encoded.
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_INST = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_PAY  = 5'b10000
    } phase_t;

    // Number of bytes in the instance id.
    localparam logic [2:0] INST_BYTES = 3'd4;

    // Width of the packed output data word.
    localparam int TDATA_W = 80;

    // One result word of the deframer.
    typedef struct packed {
        logic [13:0] packet_id;
        logic [31:0] instance_id;
        logic [23:0] packet_length;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        last_of_packet;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/variable_length_packet_deframer_core.sv -----
// Each result word is registered in the output stage before it appears on m_axis.
// One byte per cycle while the skid is empty; parser state updates on each accepted byte.
// A one-entry skid behind the result register holds one result while the output stalls.
// Reset (rst_n, asynchronous, active low) returns the parser to the first header
// byte, clears all field registers, empties the output stage and clears is_sending.
`default_nettype none

module variable_length_packet_deframer_core
    import vlpd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,       // is_sending
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,    // data_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // packet_id[13:0], instance_id[45:14], packet_length[69:46],
    // payload_byte[77:70], zero fill[79:78]
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tlast,    // last_of_packet
    output logic                    m_axis_tuser     // payload_valid
);

    logic step;
    logic res_valid;
    res_t res;
    res_t out_res;

    // A byte is taken when both sides of the input handshake agree.
    assign step = s_axis_tvalid && s_axis_tready;

    vlpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .data_byte (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    vlpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result fields onto the output bus.
    assign m_axis_tdata = {2'b00, out_res.payload_byte, out_res.packet_length,
                           out_res.instance_id, out_res.packet_id};
    assign m_axis_tlast = out_res.last_of_packet;
    assign m_axis_tuser = out_res.payload_valid;

    // An empty result always closes its packet.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty result without last marker");

    // An empty result carries a zero payload byte and a zero length.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (m_axis_tdata[77:70] == 8'h00 && m_axis_tdata[69:46] == 24'd0))
        else $error("empty result with nonzero payload or length");

    // The input closes only when the skid is full, so a result must be waiting.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

`default_nettype wire

// ----- rtl/vlpd_parser.sv -----
`default_nettype none

module vlpd_parser
    import vlpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    output logic            res_valid,
    output res_t            res
);

    logic        is_sending_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] header_reg, header_next;
    logic [31:0] inst_reg, inst_next;
    logic [23:0] len_reg, len_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [23:0] rem_reg, rem_next;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_valid;
    logic        emit_last;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_sending_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            is_sending_reg <= cfg_wdata;
        end
    end

    // Next-state logic for one incoming byte.
    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        inst_next   = inst_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        emit        = 1'b0;
        emit_byte   = 8'h00;
        emit_valid  = 1'b0;
        emit_last   = 1'b0;
        case (phase_reg)
            PH_HDR1:
            begin
                header_next = {header_reg[15:8], data_byte};
                cnt_next    = 3'd0;
                if (is_sending_reg)
                begin
                    phase_next = PH_INST;
                end
                else
                begin
                    len_next = 24'd0;
                    if (data_byte[1:0] == 2'd0)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_INST:
            begin
                inst_next = {inst_reg[23:0], data_byte};
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_next >= INST_BYTES)
                begin
                    len_next = 24'd0;
                    cnt_next = 3'd0;
                    if (header_reg[1:0] == 2'd0)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                len_next = {len_reg[15:0], data_byte};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_next >= {1'b0, header_reg[1:0]})
                begin
                    if (len_next == 24'd0)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        rem_next   = len_next;
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                rem_next   = rem_reg - 24'd1;
                emit       = 1'b1;
                emit_byte  = data_byte;
                emit_valid = 1'b1;
                if (rem_next == 24'd0)
                begin
                    emit_last  = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // First header byte; also taken for any unreachable phase code.
                header_next = {data_byte, 8'h00};
                inst_next   = 32'd0;
                len_next    = 24'd0;
                cnt_next    = 3'd0;
                rem_next    = 24'd0;
                phase_next  = PH_HDR1;
            end
        endcase
    end

    // The result carries the fields as they stand after this byte.
    assign res_valid          = step && emit;
    assign res.packet_id      = header_next[15:2];
    assign res.instance_id    = inst_next;
    assign res.packet_length  = len_next;
    assign res.payload_byte   = emit_byte;
    assign res.payload_valid  = emit_valid;
    assign res.last_of_packet = emit_last;

    // Parser state registers, updated on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            header_reg <= 16'd0;
            inst_reg   <= 32'd0;
            len_reg    <= 24'd0;
            cnt_reg    <= 3'd0;
            rem_reg    <= 24'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            inst_reg   <= inst_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vlpd_out_stage.sv -----
`default_nettype none

module vlpd_out_stage
    import vlpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_res,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic main_valid_reg;
    res_t main_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    // Input side stays open until the skid entry is occupied.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // Control: main result register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_res;
            end
        end
        else if (push)
        begin
            skid_reg <= push_res;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vlpd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 600;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;

    // Bytes waiting to be offered, and result words waiting to be seen.
    bit [7:0] stream_q[$];
    res_t     expected_results[$];

    // Idle rates in percent, and the long receiver hold-off request.
    int  send_idle = 36;
    int  recv_idle = 62;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    int  hold_left = 0;
    bit  in_took = 1'b0;

    // Shadow of the deframer state, updated on every accepted byte.
    bit          shadow_sending = 1'b0;
    phase_t      shadow_phase = PH_HDR0;
    logic [15:0] shadow_hdr = '0;
    logic [31:0] shadow_inst = '0;
    logic [23:0] shadow_len = '0;
    logic [2:0]  shadow_cnt = '0;
    logic [23:0] shadow_remain = '0;

    // Packet under construction by the stimulus generator.
    logic [13:0] gen_id;
    logic [1:0]  gen_lsize;
    logic [31:0] gen_inst;
    logic [23:0] gen_len;
    bit [7:0]    gen_payload[$];
    bit [7:0]    pkt_bytes[$];

    // Run statistics.
    int errors = 0;
    int bytes_in = 0;
    int words_out = 0;
    int packets_out = 0;
    int empty_out = 0;
    int in_stall_cycles = 0;

    variable_length_packet_deframer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Queue one result word built from the current shadow fields.
    task automatic push_result(input logic [7:0] b, input logic v, input logic l);
        res_t r;
        r.packet_id      = shadow_hdr[15:2];
        r.instance_id    = shadow_inst;
        r.packet_length  = shadow_len;
        r.payload_byte   = b;
        r.payload_valid  = v;
        r.last_of_packet = l;
        expected_results.push_back(r);
    endtask

    // The length is known: either an empty packet or the start of the payload.
    task automatic close_length();
        if (shadow_len == 24'd0) begin
            push_result(8'h00, 1'b0, 1'b1);
            shadow_phase = PH_HDR0;
        end
        else begin
            shadow_remain = shadow_len;
            shadow_phase  = PH_PAY;
        end
    endtask

    // Header (and instance id) complete: move on to the length field.
    task automatic open_length();
        shadow_len = '0;
        shadow_cnt = '0;
        if (shadow_hdr[1:0] == 2'd0)
            close_length();
        else
            shadow_phase = PH_LEN;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        case (shadow_phase)
            PH_HDR1:
            begin
                shadow_hdr[7:0] = b;
                shadow_cnt = '0;
                if (shadow_sending)
                    shadow_phase = PH_INST;
                else
                    open_length();
            end
            PH_INST:
            begin
                shadow_inst = {shadow_inst[23:0], b};
                shadow_cnt  = shadow_cnt + 3'd1;
                if (shadow_cnt >= INST_BYTES)
                    open_length();
            end
            PH_LEN:
            begin
                shadow_len = {shadow_len[15:0], b};
                shadow_cnt = shadow_cnt + 3'd1;
                if (shadow_cnt >= {1'b0, shadow_hdr[1:0]})
                    close_length();
            end
            PH_PAY:
            begin
                shadow_remain = shadow_remain - 24'd1;
                push_result(b, 1'b1, shadow_remain == 24'd0);
                if (shadow_remain == 24'd0)
                    shadow_phase = PH_HDR0;
            end
            default:
            begin
                shadow_hdr    = {b, 8'h00};
                shadow_inst   = '0;
                shadow_len    = '0;
                shadow_cnt    = '0;
                shadow_remain = '0;
                shadow_phase  = PH_HDR1;
            end
        endcase
    endtask

    // Input side: track acceptance, apply register writes, predict results.
    always @(posedge clk)
    begin
        in_took <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (cfg_we)
                shadow_sending = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata);
                bytes_in++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                in_stall_cycles++;
        end
    end

    // Sender: offer the next byte once the current word has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_took)
        begin
            if (stream_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_q.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Output side: compare each result word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.packet_id      = m_axis_tdata[13:0];
            got.instance_id    = m_axis_tdata[45:14];
            got.packet_length  = m_axis_tdata[69:46];
            got.payload_byte   = m_axis_tdata[77:70];
            got.payload_valid  = m_axis_tuser;
            got.last_of_packet = m_axis_tlast;
            words_out++;
            if (m_axis_tlast)
                packets_out++;
            if (!m_axis_tuser)
                empty_out++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                errors += !field_ok("packet_id", want.packet_id, got.packet_id);
                errors += !field_ok("instance_id", want.instance_id, got.instance_id);
                errors += !field_ok("packet_length", want.packet_length, got.packet_length);
                errors += !field_ok("payload_byte", want.payload_byte, got.payload_byte);
                errors += !field_ok("payload_valid", want.payload_valid, got.payload_valid);
                errors += !field_ok("last_of_packet", want.last_of_packet,
                                    got.last_of_packet);
            end
        end
    end

    // Wait until every byte is in and every result is out, then let it settle.
    task automatic wait_quiet();
        while (!(stream_q.size() == 0 && !s_axis_tvalid && expected_results.size() == 0))
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_sending(input bit v);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Choose random packet fields; most lengths are short, a few span two bytes.
    task automatic pick_packet();
        int r;
        int n;
        gen_id    = 14'($urandom);
        gen_lsize = 2'($urandom_range(3));
        r = $urandom_range(3);
        gen_inst  = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        r = $urandom_range(99);
        if (gen_lsize == 2'd0 || r < 10)
            n = 0;
        else if (r < 93)
            n = $urandom_range(12, 1);
        else if (gen_lsize >= 2'd2 && r >= 97)
            n = $urandom_range(300, 256);
        else
            n = $urandom_range(200, 13);
        gen_len = 24'(n);
        gen_payload.delete();
        for (int i = 0; i < n; i++)
            gen_payload.push_back(8'($urandom));
    endtask

    // Serialize the chosen packet, big-endian, with or without the instance id.
    task automatic build_packet(input bit sending);
        logic [15:0] hdr;
        hdr = {gen_id, gen_lsize};
        pkt_bytes.delete();
        pkt_bytes.push_back(hdr[15:8]);
        pkt_bytes.push_back(hdr[7:0]);
        if (sending)
            for (int i = 3; i >= 0; i--)
                pkt_bytes.push_back(gen_inst[8*i +: 8]);
        for (int i = int'(gen_lsize) - 1; i >= 0; i--)
            pkt_bytes.push_back(gen_len[8*i +: 8]);
        foreach (gen_payload[i])
            pkt_bytes.push_back(gen_payload[i]);
    endtask

    task automatic append_bytes(input int from, input int upto);
        for (int i = from; i < upto; i++)
            stream_q.push_back(pkt_bytes[i]);
    endtask

    // Cycle limit.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("variable_length_packet_deframer_core test failed");
        $finish;
    end

    initial
    begin
        // Empty packets on header and on a one-byte length, a payload with
        // extreme byte values, then two packets split by a register write.
        bit [7:0] dir_a[] = '{8'hFF, 8'hFC, 8'h00, 8'h01, 8'h00,
                              8'h12, 8'h36, 8'h00, 8'h01, 8'hFF, 8'h80};
        bit [7:0] dir_b[] = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00,
                              8'h55, 8'h00};
        bit [7:0] dir_c[] = '{8'h01, 8'h02, 8'h03, 8'h04};
        bit phase_sending[3] = '{1'b1, 1'b0, 1'b1};
        bit have_carry;
        bit carry_sending;
        int carry_cut;
        int phase_count;

        have_carry = 1'b0;
        carry_sending = 1'b0;
        carry_cut = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_sending(1'b0);

        // Directed part. The register changes once before the second header
        // byte (it takes effect) and once after it (it must not).
        foreach (dir_a[i])
            stream_q.push_back(dir_a[i]);
        wait_quiet();
        write_sending(1'b1);
        foreach (dir_b[i])
            stream_q.push_back(dir_b[i]);
        wait_quiet();
        write_sending(1'b0);
        foreach (dir_c[i])
            stream_q.push_back(dir_c[i]);

        // Random phases with different idle mixes; each one but the last ends
        // inside a packet so the next register write lands mid-frame.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 36 : (ph == 1) ? 62 : 0;
            recv_idle = (ph == 0) ? 62 : (ph == 1) ? 36 : 0;
            wait_quiet();
            write_sending(phase_sending[ph]);
            if (have_carry)
            begin
                // The second header byte decides whether an instance id follows.
                build_packet(carry_cut == 1 ? phase_sending[ph] : carry_sending);
                append_bytes(carry_cut, pkt_bytes.size());
                have_carry = 1'b0;
            end
            hold_req = ~hold_req;
            phase_count = 0;
            while (phase_count < PHASE_BYTES)
            begin
                pick_packet();
                build_packet(phase_sending[ph]);
                append_bytes(0, pkt_bytes.size());
                phase_count += pkt_bytes.size();
            end
            if (ph < 2)
            begin
                pick_packet();
                build_packet(phase_sending[ph]);
                carry_cut = $urandom_range(pkt_bytes.size() - 1, 1);
                carry_sending = phase_sending[ph];
                append_bytes(0, carry_cut);
                have_carry = 1'b1;
            end
        end
        wait_quiet();

        $display("Sent %0d bytes; checked %0d result words in %0d packets (%0d empty).",
                 bytes_in, words_out, packets_out, empty_out);
        $display("Input back-pressure seen on %0d cycles; %0d field mismatches.",
                 in_stall_cycles, errors);
        if (errors == 0)
            $display("variable_length_packet_deframer_core test passed");
        else
            $display("variable_length_packet_deframer_core test failed");
        $finish;
    end

endmodule
